@@ rtl/core/ccs_pkg.sv @@
// Shared types, constants and helpers for the ChaCha20 stream cipher core.
// Used by the controller, the datapath, the quarter-round unit and the top level.
// No dependencies.
package ccs_pkg;

  // Default number of double rounds per keystream block.
  localparam int DOUBLE_ROUNDS_DEF = 10;

  // Keystream block geometry.
  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int ITEM_BYTES  = 8;

  // "expand 32-byte k" constant words.
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  // Quarter-round rotate amounts.
  localparam int ROT_1 = 16;
  localparam int ROT_2 = 12;
  localparam int ROT_3 = 8;
  localparam int ROT_4 = 7;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_01     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_23     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_45     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_67     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_01   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_BLK  = 3'd6;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ROUND,
    S_FINAL,
    S_CONSUME,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input word
    logic init;     // load the block state from key, counter and nonce
    logic round;    // one column or diagonal round
    logic diag;     // diagonal round when set
    logic final_add; // feed-forward add
    logic consume;  // use keystream bytes for the current word
    logic emit;     // move the finished word to the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;  // no bytes left in the current word
    logic pos_zero;  // keystream block fully used
    logic fits;      // remaining bytes fit in the current block
    logic out_full;  // output register holds a word
  } dp_status_t;

  // 32-bit rotate left by a constant amount.
  function automatic logic [31:0] rotl32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

@@ rtl/core/ccs_qround.sv @@
// ChaCha quarter-round: four add, xor and rotate steps on four words.
// Depends on ccs_pkg for the rotate helper and amounts.
module ccs_qround (
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  input  logic [31:0] c_in,
  input  logic [31:0] d_in,
  output logic [31:0] a_out,
  output logic [31:0] b_out,
  output logic [31:0] c_out,
  output logic [31:0] d_out
);

  logic [31:0] a1, b1, c1, d1;

  // First half: rotates by 16 and 12.
  always_comb begin
    a1 = a_in + b_in;
    d1 = ccs_pkg::rotl32(d_in ^ a1, ccs_pkg::ROT_1);
    c1 = c_in + d1;
    b1 = ccs_pkg::rotl32(b_in ^ c1, ccs_pkg::ROT_2);
  end

  // Second half: rotates by 8 and 7.
  always_comb begin
    a_out = a1 + b1;
    d_out = ccs_pkg::rotl32(d1 ^ a_out, ccs_pkg::ROT_3);
    c_out = c1 + d_out;
    b_out = ccs_pkg::rotl32(b1 ^ c_out, ccs_pkg::ROT_4);
  end

endmodule

@@ rtl/core/ccs_datapath.sv @@
// Datapath of the ChaCha20 stream cipher: configuration registers, block state,
// four quarter-round units, byte consumption and the output register.
// Depends on ccs_pkg and ccs_qround.
module ccs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_wdata,
  input  logic [63:0]                     data_in,
  input  logic [3:0]                      byte_count,
  input  logic                            end_of_message,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [63:0]                     data_out,
  output logic [3:0]                      out_byte_count,
  output logic                            out_last,
  input  ccs_pkg::ctrl_cmd_t              cmd,
  output ccs_pkg::dp_status_t             status
);

  // Configuration and control registers.
  logic [63:0] key_01, key_23, key_45, key_67, nonce_01;
  logic [31:0] nonce_2;
  logic [31:0] block_counter;
  logic [5:0]  byte_pos;

  // Current word being processed.
  logic [63:0] data_r;
  logic [3:0]  count_r;
  logic        last_r;
  logic [3:0]  rem;
  logic [3:0]  done;
  logic [63:0] result;

  // Block state: round state during a build, keystream bytes afterward.
  logic [ccs_pkg::BLOCK_WORDS-1:0][31:0] blk;
  logic [ccs_pkg::BLOCK_WORDS-1:0][31:0] init_w;
  logic [ccs_pkg::BLOCK_WORDS-1:0][31:0] blk_rnd;
  logic [ccs_pkg::BLOCK_WORDS-1:0][31:0] blk_add;

  logic [3:0]  count_clamp;
  logic [6:0]  avail;
  logic        fits;
  logic [3:0]  take;
  logic [6:0]  pos_sum;
  logic [63:0] ks_low;
  logic [63:0] result_next;

  logic [3:0][31:0] qa, qb, qc, qd;
  logic [3:0][31:0] ra, rb, rc, rd;

  // Initial block words from the constant, key, counter and nonce.
  always_comb begin
    init_w[0]  = ccs_pkg::SIGMA_0;
    init_w[1]  = ccs_pkg::SIGMA_1;
    init_w[2]  = ccs_pkg::SIGMA_2;
    init_w[3]  = ccs_pkg::SIGMA_3;
    init_w[4]  = key_01[31:0];
    init_w[5]  = key_01[63:32];
    init_w[6]  = key_23[31:0];
    init_w[7]  = key_23[63:32];
    init_w[8]  = key_45[31:0];
    init_w[9]  = key_45[63:32];
    init_w[10] = key_67[31:0];
    init_w[11] = key_67[63:32];
    init_w[12] = block_counter;
    init_w[13] = nonce_01[31:0];
    init_w[14] = nonce_01[63:32];
    init_w[15] = nonce_2;
  end

  // Operand selection: columns, or diagonals shifted by one lane per row.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      qa[j] = blk[j];
      qb[j] = cmd.diag ? blk[4 + ((j + 1) % 4)]  : blk[4 + j];
      qc[j] = cmd.diag ? blk[8 + ((j + 2) % 4)]  : blk[8 + j];
      qd[j] = cmd.diag ? blk[12 + ((j + 3) % 4)] : blk[12 + j];
    end
  end

  // Four quarter-round units working in parallel.
  for (genvar g = 0; g < 4; g++) begin : g_qr
    ccs_qround u_qround (
      .a_in  (qa[g]),
      .b_in  (qb[g]),
      .c_in  (qc[g]),
      .d_in  (qd[g]),
      .a_out (ra[g]),
      .b_out (rb[g]),
      .c_out (rc[g]),
      .d_out (rd[g])
    );
  end

  // Write the quarter-round results back to the words they came from.
  always_comb begin
    blk_rnd = blk;
    for (int j = 0; j < 4; j++) begin
      blk_rnd[j] = ra[j];
      if (cmd.diag) begin
        blk_rnd[4 + ((j + 1) % 4)]  = rb[j];
        blk_rnd[8 + ((j + 2) % 4)]  = rc[j];
        blk_rnd[12 + ((j + 3) % 4)] = rd[j];
      end else begin
        blk_rnd[4 + j]  = rb[j];
        blk_rnd[8 + j]  = rc[j];
        blk_rnd[12 + j] = rd[j];
      end
    end
  end

  // Feed-forward add.
  always_comb begin
    for (int i = 0; i < ccs_pkg::BLOCK_WORDS; i++) begin
      blk_add[i] = blk[i] + init_w[i];
    end
  end

  // Byte consumption: take what fits in the current block.
  assign count_clamp = (byte_count > 4'(ccs_pkg::ITEM_BYTES)) ?
                       4'(ccs_pkg::ITEM_BYTES) : byte_count;
  assign avail   = 7'(ccs_pkg::BLOCK_BYTES) - {1'b0, byte_pos};
  assign fits    = {3'b000, rem} <= avail;
  assign take    = fits ? rem : avail[3:0];
  assign pos_sum = {1'b0, byte_pos} + {3'b000, take};
  assign ks_low  = blk[1:0];

  // Place the keystream bytes at the output byte lanes still open.
  always_comb begin
    logic [3:0] lane;
    logic [3:0] rel;
    logic [3:0] stop;
    result_next = result;
    stop = done + take;
    for (int i = 0; i < ccs_pkg::ITEM_BYTES; i++) begin
      lane = 4'(i);
      rel  = lane - done;
      if ((lane >= done) && (lane < stop)) begin
        result_next[8*i +: 8] = data_r[8*i +: 8] ^ ks_low[{rel[2:0], 3'b000} +: 8];
      end
    end
  end

  // Status for the controller.
  assign status.rem_zero = (rem == 4'd0);
  assign status.pos_zero = (byte_pos == 6'd0);
  assign status.fits     = fits;
  assign status.out_full = out_valid;

  // Control registers: configuration, counter, position and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_01        <= '0;
      key_23        <= '0;
      key_45        <= '0;
      key_67        <= '0;
      nonce_01      <= '0;
      nonce_2       <= '0;
      block_counter <= '0;
      byte_pos      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ccs_pkg::REG_KEY_01:    key_01   <= cfg_wdata;
          ccs_pkg::REG_KEY_23:    key_23   <= cfg_wdata;
          ccs_pkg::REG_KEY_45:    key_45   <= cfg_wdata;
          ccs_pkg::REG_KEY_67:    key_67   <= cfg_wdata;
          ccs_pkg::REG_NONCE_01:  nonce_01 <= cfg_wdata;
          ccs_pkg::REG_NONCE_2:   nonce_2  <= cfg_wdata[31:0];
          ccs_pkg::REG_START_BLK: begin
            block_counter <= cfg_wdata[31:0];
            byte_pos      <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.consume) begin
        byte_pos <= pos_sum[5:0];
        if (pos_sum[6]) begin
          block_counter <= block_counter + 32'd1;
        end
      end
      // The output register refills on emit and empties when accepted.
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (last_r) begin
          byte_pos <= '0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: current word, block state and output word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r  <= data_in;
      count_r <= count_clamp;
      last_r  <= end_of_message;
      rem     <= count_clamp;
      done    <= '0;
      result  <= '0;
    end
    if (cmd.init) begin
      blk <= init_w;
    end
    if (cmd.round) begin
      blk <= blk_rnd;
    end
    if (cmd.final_add) begin
      blk <= blk_add;
    end
    if (cmd.consume) begin
      blk    <= blk >> {take, 3'b000};
      result <= result_next;
      rem    <= rem - take;
      done   <= done + take;
    end
    if (cmd.emit) begin
      data_out       <= result;
      out_byte_count <= count_r;
      out_last       <= last_r;
    end
  end

endmodule

@@ rtl/core/ccs_ctrl.sv @@
// Controller of the ChaCha20 stream cipher: sequences word capture, block
// builds, byte consumption and output. Depends on ccs_pkg.
module ccs_ctrl #(
  parameter int DOUBLE_ROUNDS = ccs_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_stall,
  input  ccs_pkg::dp_status_t  status,
  output ccs_pkg::ctrl_cmd_t   cmd
);

  localparam int RW = (2 * DOUBLE_ROUNDS > 1) ? $clog2(2 * DOUBLE_ROUNDS) : 1;
  localparam logic [RW-1:0] LAST_ROUND = RW'(2 * DOUBLE_ROUNDS - 1);

  ccs_pkg::state_t state, state_next;
  logic [RW-1:0]   round_cnt, round_cnt_next;

  // State and round counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccs_pkg::S_IDLE;
      round_cnt <= '0;
    end else begin
      state     <= state_next;
      round_cnt <= round_cnt_next;
    end
  end

  assign in_stall = (state != ccs_pkg::S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    round_cnt_next = round_cnt;
    cmd            = '0;
    cmd.diag       = round_cnt[0];
    case (state)
      ccs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ccs_pkg::S_DISPATCH;
        end
      end
      ccs_pkg::S_DISPATCH: begin
        if (status.rem_zero) begin
          state_next = ccs_pkg::S_EMIT;
        end else if (status.pos_zero) begin
          cmd.init       = 1'b1;
          round_cnt_next = '0;
          state_next     = ccs_pkg::S_ROUND;
        end else begin
          cmd.consume = 1'b1;
          if (status.fits) begin
            state_next = ccs_pkg::S_EMIT;
          end
        end
      end
      ccs_pkg::S_ROUND: begin
        cmd.round = 1'b1;
        if (round_cnt == LAST_ROUND) begin
          state_next = ccs_pkg::S_FINAL;
        end else begin
          round_cnt_next = round_cnt + RW'(1);
        end
      end
      ccs_pkg::S_FINAL: begin
        cmd.final_add = 1'b1;
        state_next    = ccs_pkg::S_CONSUME;
      end
      ccs_pkg::S_CONSUME: begin
        // A fresh block is ready, so consume without a build check.
        cmd.consume = 1'b1;
        state_next  = status.fits ? ccs_pkg::S_EMIT : ccs_pkg::S_DISPATCH;
      end
      ccs_pkg::S_EMIT: begin
        if (!status.out_full || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = ccs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ccs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/chacha20_stream_cipher.sv @@
// Channel | direction | handshake          | payload
// cfg     | in        | cfg_we             | cfg_index, cfg_wdata
// in      | in        | in_valid, in_stall | data_in, byte_count, end_of_message
// out     | out       | out_valid, out_stall | data_out, out_byte_count, out_last
//
// A word passes through capture, consume and the write to the output register.
// A word that starts a keystream block also waits for the block build (load,
// one column or diagonal round per cycle on four quarter-round units,
// feed-forward add); a word that crosses a block adds it once.
// A stalled output holds the finished word; the next word is taken meanwhile
// and waits in the output stage until the register frees.
// Reset (rst, synchronous) clears configuration, counter, position and the output valid.
//
// Top level of the ChaCha20 stream cipher. Depends on ccs_pkg, ccs_ctrl and
// ccs_datapath.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = ccs_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [63:0]                   data_in,
  input  logic [3:0]                    byte_count,
  input  logic                          end_of_message,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [63:0]                   data_out,
  output logic [3:0]                    out_byte_count,
  output logic                          out_last
);

  ccs_pkg::ctrl_cmd_t  cmd;
  ccs_pkg::dp_status_t status;

  // Sequencer.
  ccs_ctrl #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Block state, rounds and byte handling.
  ccs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .data_in        (data_in),
    .byte_count     (byte_count),
    .end_of_message (end_of_message),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .data_out       (data_out),
    .out_byte_count (out_byte_count),
    .out_last       (out_last),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

@@ rtl/core/ccs_checker.sv @@
// Port-level checks for the ChaCha20 stream cipher, bound to the top level.
// Depends on ccs_pkg and chacha20_stream_cipher.
module ccs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [63:0]                   data_out,
  input logic [3:0]                    out_byte_count,
  input logic                          out_last
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out) &&
      $stable(out_byte_count) && $stable(out_last))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A captured word is worked on before another is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in back-to-back cycles");

  // Byte counts are clamped to a full word.
  a_count_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_byte_count <= 4'(ccs_pkg::ITEM_BYTES))
    else $error("output byte count above eight");

  // A word with no valid bytes carries zero data.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte_count == 4'd0 |-> data_out == 64'd0)
    else $error("empty output word has data");

endmodule

bind chacha20_stream_cipher ccs_checker u_ccs_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the ChaCha20 stream cipher core.
// Drives words, checks each output word against a built-in keystream predictor.
// Depends on ccs_pkg and the chacha20_stream_cipher RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ccs_pkg::*;

  localparam int MIX_ROUNDS     = 10;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASE_WORDS    = 100;
  localparam int PHASE_COUNT    = 7;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 60;
  localparam int ROW_COUNT      = 20;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } cipher_word_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        eom;
    logic        typed;
    logic [63:0] known_data;
    logic [3:0]  known_count;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic [63:0] data_in = '0;
  logic [3:0]  byte_count = '0;
  logic        end_of_message = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] data_out;
  logic [3:0]  out_byte_count;
  logic        out_last;

  // Predictor state: configuration, running counter, position and current block.
  logic [63:0] key_pair [4] = '{default: '0};
  logic [63:0] nonce_pair = '0;
  logic [31:0] nonce_top = '0;
  logic [31:0] block_ctr = '0;
  logic [5:0]  stream_pos = '0;
  logic [31:0] ks_words [16] = '{default: '0};
  logic [31:0] mix_w [16];

  cipher_word_t expected_words [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 15;
  int          receiver_idle_pct = 58;
  bit          pressure_armed = 1'b0;
  bit          pressure_done = 1'b0;
  int          hold_left = 0;

  // Directed words; typed rows carry a result known without the predictor
  // (zero-key keystream right after reset, zero byte counts).
  stim_row_t directed_rows [ROW_COUNT] = '{
    '{64'h0, 4'd8, 1'b0, 1'b1, 64'h903df1a0ade0b876, 4'd8},
    '{64'h0, 4'd8, 1'b0, 1'b1, 64'h28bd8653e56a5d40, 4'd8},
    '{64'hffffffffffffffff, 4'd8, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h0123456789abcdef, 4'd3, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'hfedcba9876543210, 4'd5, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'ha5a5a5a5a5a5a5a5, 4'd15, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h5a5a5a5a5a5a5a5a, 4'd9, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h1111111111111111, 4'd6, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h2222222222222222, 4'd8, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h3333333333333333, 4'd8, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'hdeadbeefcafef00d, 4'd0, 1'b0, 1'b1, 64'h0, 4'd0},
    '{64'hffffffffffffffff, 4'd0, 1'b1, 1'b1, 64'h0, 4'd0},
    '{64'hffffffffffffffff, 4'd1, 1'b1, 1'b0, 64'h0, 4'd0},
    '{64'h0, 4'd8, 1'b1, 1'b0, 64'h0, 4'd0},
    '{64'hffffffffffffffff, 4'd8, 1'b1, 1'b0, 64'h0, 4'd0},
    '{64'h0, 4'd0, 1'b1, 1'b1, 64'h0, 4'd0},
    '{64'h8000000000000001, 4'd2, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h7ffffffffffffffe, 4'd8, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'hc3c3c3c3c3c3c3c3, 4'd4, 1'b1, 1'b0, 64'h0, 4'd0},
    '{64'h0f0f0f0f0f0f0f0f, 4'd15, 1'b1, 1'b0, 64'h0, 4'd0}
  };

  chacha20_stream_cipher #(
    .DOUBLE_ROUNDS(MIX_ROUNDS)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_in        (data_in),
    .byte_count     (byte_count),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_out       (data_out),
    .out_byte_count (out_byte_count),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    logic [63:0] twice;
    twice = {v, v} << n;
    return twice[63:32];
  endfunction

  // One quarter round on the working block.
  function automatic void quarter_mix(int a, int b, int c, int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 7);
  endfunction

  // Builds the next keystream block from key, counter and nonce.
  function automatic void refill_keystream();
    logic [31:0] init_w [16];
    init_w[0] = 32'h61707865;
    init_w[1] = 32'h3320646e;
    init_w[2] = 32'h79622d32;
    init_w[3] = 32'h6b206574;
    for (int k = 0; k < 4; k++) begin
      init_w[4 + 2 * k] = key_pair[k][31:0];
      init_w[5 + 2 * k] = key_pair[k][63:32];
    end
    init_w[12] = block_ctr;
    init_w[13] = nonce_pair[31:0];
    init_w[14] = nonce_pair[63:32];
    init_w[15] = nonce_top;
    mix_w = init_w;
    for (int r = 0; r < MIX_ROUNDS; r++) begin
      quarter_mix(0, 4, 8, 12);
      quarter_mix(1, 5, 9, 13);
      quarter_mix(2, 6, 10, 14);
      quarter_mix(3, 7, 11, 15);
      quarter_mix(0, 5, 10, 15);
      quarter_mix(1, 6, 11, 12);
      quarter_mix(2, 7, 8, 13);
      quarter_mix(3, 4, 9, 14);
    end
    for (int k = 0; k < 16; k++) begin
      ks_words[k] = mix_w[k] + init_w[k];
    end
  endfunction

  // XORs the valid bytes of one word with the keystream and advances the position.
  function automatic cipher_word_t encipher_word(logic [63:0] din, logic [3:0] cnt,
                                                 logic eom);
    cipher_word_t res;
    logic [31:0]  ks_sel;
    int           n;
    n = (cnt > 4'd8) ? 8 : int'(cnt);
    res.data = '0;
    res.count = 4'(n);
    res.last = eom;
    for (int i = 0; i < n; i++) begin
      if (stream_pos == 6'd0) begin
        refill_keystream();
      end
      ks_sel = ks_words[stream_pos[5:2]] >> {stream_pos[1:0], 3'b000};
      res.data[8 * i +: 8] = din[8 * i +: 8] ^ ks_sel[7:0];
      if (stream_pos == 6'd63) begin
        block_ctr = block_ctr + 32'd1;
      end
      stream_pos = stream_pos + 6'd1;
    end
    // The last word of a message drops the rest of the block.
    if (eom) begin
      stream_pos = '0;
    end
    return res;
  endfunction

  // Writes one register and mirrors it in the predictor.
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_KEY_01:    key_pair[0] = val;
      REG_KEY_23:    key_pair[1] = val;
      REG_KEY_45:    key_pair[2] = val;
      REG_KEY_67:    key_pair[3] = val;
      REG_NONCE_01:  nonce_pair = val;
      REG_NONCE_2:   nonce_top = val[31:0];
      REG_START_BLK: begin
        block_ctr = val[31:0];
        stream_pos = '0;
      end
      default: ;
    endcase
  endtask

  task automatic program_all(logic [63:0] k01, logic [63:0] k23, logic [63:0] k45,
                             logic [63:0] k67, logic [63:0] n01, logic [31:0] n2,
                             logic [31:0] start);
    program_reg(REG_KEY_01, k01);
    program_reg(REG_KEY_23, k23);
    program_reg(REG_KEY_45, k45);
    program_reg(REG_KEY_67, k67);
    program_reg(REG_NONCE_01, n01);
    program_reg(REG_NONCE_2, {32'h0, n2});
    program_reg(REG_START_BLK, {32'h0, start});
  endtask

  // Offers one input word until it is taken, then records its expected result.
  task automatic send_word(logic [63:0] d, logic [3:0] c, logic e, logic typed,
                           cipher_word_t known);
    cipher_word_t predicted;
    while (chance(sender_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_in <= d;
    byte_count <= c;
    end_of_message <= e;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = encipher_word(d, c, e);
    expected_words.push_back(typed ? known : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Output side: compare every accepted word with the oldest expectation.
  always @(posedge clk) begin
    cipher_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, actual %h", $time, data_out);
      end else begin
        want = expected_words.pop_front();
        if (data_out !== want.data) begin
          mismatches++;
          $display("%0t: data_out expected %h actual %h", $time, want.data, data_out);
        end
        if (out_byte_count !== want.count) begin
          mismatches++;
          $display("%0t: out_byte_count expected %0d actual %0d", $time, want.count,
                   out_byte_count);
        end
        if (out_last !== want.last) begin
          mismatches++;
          $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
        end
      end
    end
  end

  // Output stall: random, plus one long hold-off that backs up the pipeline.
  always @(posedge clk) begin
    if (pressure_armed && !pressure_done) begin
      hold_left = HOLD_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= chance(receiver_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    cipher_word_t known;
    logic [63:0]  d;
    logic [3:0]   c;
    logic         e;
    bit           noise;
    int           msg_left;
    msg_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset configuration.
    for (int r = 0; r < ROW_COUNT; r++) begin
      known = '{directed_rows[r].known_data, directed_rows[r].known_count,
                directed_rows[r].eom};
      send_word(directed_rows[r].data, directed_rows[r].count, directed_rows[r].eom,
                directed_rows[r].typed, known);
    end

    // Random phases, each reprogramming some or all of the key, nonce and counter.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_idle();
      case (ph)
        0: program_all('1, '1, '1, '1, '1, '1, 32'hffffffff);
        1: program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
        2: begin
          // Key and nonce change while the current block may be part used.
          program_reg(REG_KEY_23, {$urandom, $urandom});
          program_reg(REG_NONCE_2, {32'h0, $urandom});
        end
        3: program_all('0, '0, '0, '0, '0, '0, 32'hfffffffe);
        4: begin
          program_reg(REG_KEY_01, {$urandom, $urandom});
          program_reg(REG_KEY_67, {$urandom, $urandom});
          program_reg(REG_NONCE_01, {$urandom, $urandom});
        end
        5: program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
        default: program_reg(REG_START_BLK, {32'h0, $urandom});
      endcase
      cfg_we <= 1'b0;
      if (ph < 2) begin
        sender_idle_pct = 15;
        receiver_idle_pct = 58;
      end else if (ph < 4) begin
        sender_idle_pct = 58;
        receiver_idle_pct = 15;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (ph == PRESSURE_PHASE) begin
        pressure_armed = 1'b1;
      end
      for (int w = 0; w < PHASE_WORDS; w++) begin
        // Mostly well-formed messages of full words with a last word of 1 to 8 bytes.
        if (msg_left == 0) begin
          msg_left = chance(30) ? $urandom_range(3, 1) : $urandom_range(24, 4);
        end
        noise = chance(12);
        d = {$urandom, $urandom};
        if (noise) begin
          c = 4'($urandom_range(15, 0));
          e = 1'($urandom_range(1, 0));
          if (e) begin
            msg_left = 0;
          end
        end else begin
          msg_left--;
          e = (msg_left == 0);
          c = e ? 4'($urandom_range(8, 1)) : 4'd8;
        end
        send_word(d, c, e, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
    end
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ chacha20_stream_cipher.f @@
rtl/core/ccs_pkg.sv
rtl/core/ccs_qround.sv
rtl/core/ccs_datapath.sv
rtl/core/ccs_ctrl.sv
rtl/core/chacha20_stream_cipher.sv
rtl/core/ccs_checker.sv
tb/testbench.sv
